// ===== design/swhsr_pkg.sv =====
// Package for the single-wire humidity sensor reader.
// Holds the shared widths, register indexes, reset values and types.
// No dependencies; every other design file uses it.
package swhsr_pkg;

    localparam int CNT_W       = 16;
    localparam int CFG_W       = 16;
    localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int BYTE_W      = 8;
    localparam int FRAME_BYTES = 5;
    localparam int FRAME_BITS  = 40;
    localparam int BITCNT_W    = 6;
    localparam int IDX_W       = 3;
    localparam int BITPOS_W    = 3;
    localparam int SUM_W       = BYTE_W + 2;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 48;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;
    localparam int REG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BITPOS_W-1:0] BIT_MSB = BITPOS_W'(BYTE_W - 1);

    localparam logic [REG_IDX_W-1:0] REG_START_LOW     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ONE_THRESHOLD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_BIT       = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT       = 2'd3;

    localparam logic [CFG_W-1:0] START_LOW_RESET     = 16'd18000;
    localparam logic [CFG_W-1:0] ONE_THRESHOLD_RESET = 16'd90;
    localparam logic [CFG_W-1:0] MAX_BIT_RESET       = 16'd135;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET       = 16'd4608;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_REQUEST = 5'b00010,
        PH_SYNC    = 5'b00100,
        PH_RECEIVE = 5'b01000,
        PH_CHECK   = 5'b10000
    } phase_t;

    typedef enum logic [2:0] {
        SYNC_WAIT_LOW  = 3'b001,
        SYNC_WAIT_HIGH = 3'b010,
        SYNC_WAIT_FALL = 3'b100
    } sync_t;

    typedef struct packed {
        logic [CFG_W-1:0] start_low_ticks;
        logic [CFG_W-1:0] one_threshold_ticks;
        logic [CFG_W-1:0] max_bit_ticks;
        logic [CFG_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic line_level;
    } item_t;

    // Packed so that the struct equals the m_tdata layout, drive_low in bit 0.
    typedef struct packed {
        logic [5:0]          pad;
        logic [BITCNT_W-1:0] bits_received;
        logic [BYTE_W-1:0]   temperature_fraction;
        logic [BYTE_W-1:0]   temperature_whole;
        logic [BYTE_W-1:0]   humidity_fraction;
        logic [BYTE_W-1:0]   humidity_whole;
        logic                checksum_ok;
        logic                done_res;
        logic                busy_res;
        logic                drive_low;
    } result_t;

endpackage

// ===== design/swhsr_front.sv =====
// Front end of the sensor reader: takes tick words and classifies them.
// Classified words wait in a short queue for the back end.
// Depends on swhsr_pkg.
module swhsr_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [swhsr_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                            s_tuser,
    output swhsr_pkg::item_t                q_item,
    output logic                            q_valid,
    input  logic                            q_pop
);

    swhsr_pkg::item_t                  queue_reg [swhsr_pkg::QUEUE_DEPTH];
    logic [swhsr_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [swhsr_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [swhsr_pkg::QCNT_W-1:0]      count_reg;
    logic                              push;
    logic                              pop;
    swhsr_pkg::item_t                  item_in;

    assign s_tready = (count_reg != swhsr_pkg::QCNT_W'(swhsr_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];

    always_comb
    begin
        item_in.start      = s_tuser;
        item_in.line_level = s_tdata[0];
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/swhsr_back.sv =====
// Back end of the sensor reader: the measurement sequencer, bit decoder and
// frame store, followed by the result register. Depends on swhsr_pkg.
module swhsr_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  swhsr_pkg::cfg_t                 cfg,
    input  swhsr_pkg::item_t                q_item,
    input  logic                            q_valid,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [swhsr_pkg::M_TDATA_W-1:0] m_tdata
);

    swhsr_pkg::phase_t                  phase_reg, phase_next;
    swhsr_pkg::sync_t                   sync_reg, sync_next;
    logic [swhsr_pkg::CNT_W-1:0]        period_cnt_reg, period_cnt_next, period_inc;
    logic [swhsr_pkg::CNT_W-1:0]        timeout_cnt_reg, timeout_cnt_next, timeout_inc;
    logic                               prev_level_reg, prev_level_next;
    logic [swhsr_pkg::BYTE_W-1:0]       frame_reg [swhsr_pkg::FRAME_BYTES];
    logic [swhsr_pkg::BYTE_W-1:0]       frame_next [swhsr_pkg::FRAME_BYTES];
    logic [swhsr_pkg::IDX_W-1:0]        byte_idx_reg, byte_idx_next;
    logic [swhsr_pkg::BITPOS_W-1:0]     bit_pos_reg, bit_pos_next;
    logic [swhsr_pkg::BITCNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic                               sum_ok_reg, sum_ok_next;
    logic                               done;
    logic [swhsr_pkg::SUM_W-1:0]        sum;
    logic                               advance;
    logic                               m_tvalid_reg;
    swhsr_pkg::result_t                 result_reg, result_next;

    assign advance  = q_valid && (!m_tvalid_reg || m_tready);
    assign q_pop    = advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = result_reg;

    assign period_inc  = (period_cnt_reg == '1) ? period_cnt_reg : period_cnt_reg + 1'b1;
    assign timeout_inc = (timeout_cnt_reg == '1) ? timeout_cnt_reg : timeout_cnt_reg + 1'b1;
    assign sum = swhsr_pkg::SUM_W'(frame_reg[0]) + swhsr_pkg::SUM_W'(frame_reg[1])
               + swhsr_pkg::SUM_W'(frame_reg[2]) + swhsr_pkg::SUM_W'(frame_reg[3]);

    always_comb
    begin
        phase_next       = phase_reg;
        sync_next        = sync_reg;
        period_cnt_next  = period_cnt_reg;
        timeout_cnt_next = timeout_cnt_reg;
        prev_level_next  = prev_level_reg;
        frame_next       = frame_reg;
        byte_idx_next    = byte_idx_reg;
        bit_pos_next     = bit_pos_reg;
        bit_cnt_next     = bit_cnt_reg;
        sum_ok_next      = sum_ok_reg;
        done             = 1'b0;

        case (phase_reg)
            swhsr_pkg::PH_IDLE:
            begin
                if (q_item.start)
                begin
                    for (int i = 0; i < swhsr_pkg::FRAME_BYTES; i++)
                    begin
                        frame_next[i] = '0;
                    end
                    byte_idx_next    = '0;
                    bit_pos_next     = swhsr_pkg::BIT_MSB;
                    bit_cnt_next     = '0;
                    prev_level_next  = 1'b0;
                    sync_next        = swhsr_pkg::SYNC_WAIT_LOW;
                    sum_ok_next      = 1'b0;
                    period_cnt_next  = '0;
                    timeout_cnt_next = '0;
                    phase_next       = swhsr_pkg::PH_REQUEST;
                end
            end
            swhsr_pkg::PH_REQUEST:
            begin
                period_cnt_next = period_inc;
                if (swhsr_pkg::CMP_W'(period_inc) > swhsr_pkg::CMP_W'(cfg.start_low_ticks))
                begin
                    period_cnt_next  = '0;
                    timeout_cnt_next = '0;
                    sync_next        = swhsr_pkg::SYNC_WAIT_LOW;
                    phase_next       = swhsr_pkg::PH_SYNC;
                end
            end
            swhsr_pkg::PH_SYNC:
            begin
                if (swhsr_pkg::CMP_W'(timeout_cnt_reg) >= swhsr_pkg::CMP_W'(cfg.timeout_ticks))
                begin
                    phase_next       = swhsr_pkg::PH_RECEIVE;
                    period_cnt_next  = '0;
                    timeout_cnt_next = '0;
                end
                else
                begin
                    timeout_cnt_next = timeout_inc;
                    case (sync_reg)
                        swhsr_pkg::SYNC_WAIT_LOW:
                        begin
                            if (!q_item.line_level)
                            begin
                                sync_next = swhsr_pkg::SYNC_WAIT_HIGH;
                            end
                        end
                        swhsr_pkg::SYNC_WAIT_HIGH:
                        begin
                            if (q_item.line_level)
                            begin
                                sync_next = swhsr_pkg::SYNC_WAIT_FALL;
                            end
                        end
                        default:
                        begin
                            if (!q_item.line_level)
                            begin
                                sync_next        = swhsr_pkg::SYNC_WAIT_LOW;
                                phase_next       = swhsr_pkg::PH_RECEIVE;
                                period_cnt_next  = '0;
                                timeout_cnt_next = '0;
                            end
                        end
                    endcase
                end
            end
            swhsr_pkg::PH_RECEIVE:
            begin
                period_cnt_next = period_inc;
                if (!q_item.line_level && prev_level_reg)
                begin
                    period_cnt_next = '0;
                    if ((swhsr_pkg::CMP_W'(period_inc) < swhsr_pkg::CMP_W'(cfg.max_bit_ticks))
                        && (bit_cnt_reg < swhsr_pkg::BITCNT_W'(swhsr_pkg::FRAME_BITS))
                        && (byte_idx_reg < swhsr_pkg::IDX_W'(swhsr_pkg::FRAME_BYTES)))
                    begin
                        if (swhsr_pkg::CMP_W'(period_inc)
                            >= swhsr_pkg::CMP_W'(cfg.one_threshold_ticks))
                        begin
                            for (int i = 0; i < swhsr_pkg::FRAME_BYTES; i++)
                            begin
                                if (byte_idx_reg == swhsr_pkg::IDX_W'(i))
                                begin
                                    frame_next[i][bit_pos_reg] = 1'b1;
                                end
                            end
                        end
                        bit_cnt_next = bit_cnt_reg + 1'b1;
                        if (bit_pos_reg == '0)
                        begin
                            byte_idx_next = byte_idx_reg + 1'b1;
                            bit_pos_next  = swhsr_pkg::BIT_MSB;
                        end
                        else
                        begin
                            bit_pos_next = bit_pos_reg - 1'b1;
                        end
                    end
                end
                prev_level_next  = q_item.line_level;
                timeout_cnt_next = timeout_inc;
                if (swhsr_pkg::CMP_W'(timeout_inc) >= swhsr_pkg::CMP_W'(cfg.timeout_ticks))
                begin
                    phase_next = swhsr_pkg::PH_CHECK;
                end
            end
            default:
            begin
                sum_ok_next = (sum[swhsr_pkg::BYTE_W-1:0] == frame_reg[4]);
                done        = 1'b1;
                phase_next  = swhsr_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_next                      = '0;
        result_next.drive_low            = (phase_next == swhsr_pkg::PH_REQUEST);
        result_next.busy_res             = (phase_next != swhsr_pkg::PH_IDLE);
        result_next.done_res             = done;
        result_next.checksum_ok          = sum_ok_next;
        result_next.humidity_whole       = frame_next[0];
        result_next.humidity_fraction    = frame_next[1];
        result_next.temperature_whole    = frame_next[2];
        result_next.temperature_fraction = frame_next[3];
        result_next.bits_received        = bit_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= swhsr_pkg::PH_IDLE;
            sync_reg        <= swhsr_pkg::SYNC_WAIT_LOW;
            period_cnt_reg  <= '0;
            timeout_cnt_reg <= '0;
            prev_level_reg  <= 1'b0;
            for (int i = 0; i < swhsr_pkg::FRAME_BYTES; i++)
            begin
                frame_reg[i] <= '0;
            end
            byte_idx_reg    <= '0;
            bit_pos_reg     <= swhsr_pkg::BIT_MSB;
            bit_cnt_reg     <= '0;
            sum_ok_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg       <= phase_next;
                sync_reg        <= sync_next;
                period_cnt_reg  <= period_cnt_next;
                timeout_cnt_reg <= timeout_cnt_next;
                prev_level_reg  <= prev_level_next;
                frame_reg       <= frame_next;
                byte_idx_reg    <= byte_idx_next;
                bit_pos_reg     <= bit_pos_next;
                bit_cnt_reg     <= bit_cnt_next;
                sum_ok_reg      <= sum_ok_next;
                m_tvalid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== design/single_wire_humidity_sensor_reader.sv =====
// Top level of the single-wire humidity sensor reader: register block, front end
// with its queue, and back end with the result register.
// Depends on swhsr_pkg, swhsr_front and swhsr_back.
//
// Each input word is one timer tick and gives exactly one result word. The block
// takes one tick per clock cycle, back to back, while m_tready is held high; each
// tick passes through the two-entry input queue and then the result register. The
// sequencer updates its state once per tick, which is what sets this rate.
// A start in s_tuser is honoured only while no measurement is running. The
// registers must be written only while the block is idle.
module single_wire_humidity_sensor_reader
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [swhsr_pkg::S_TDATA_W-1:0]  s_tdata,   // [0] line_level
    input  logic                             s_tuser,   // [0] command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] checksum_ok,
    // [11:4] humidity_whole, [19:12] humidity_fraction, [27:20] temperature_whole,
    // [35:28] temperature_fraction, [41:36] bits_received
    output logic [swhsr_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [swhsr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [swhsr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [swhsr_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);

    swhsr_pkg::cfg_t                    cfg_reg;
    swhsr_pkg::item_t                   q_item;
    logic                               q_valid;
    logic                               q_pop;
    logic [swhsr_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[swhsr_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks     <= swhsr_pkg::START_LOW_RESET;
            cfg_reg.one_threshold_ticks <= swhsr_pkg::ONE_THRESHOLD_RESET;
            cfg_reg.max_bit_ticks       <= swhsr_pkg::MAX_BIT_RESET;
            cfg_reg.timeout_ticks       <= swhsr_pkg::TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                swhsr_pkg::REG_START_LOW:
                begin
                    cfg_reg.start_low_ticks <= pwdata[swhsr_pkg::CFG_W-1:0];
                end
                swhsr_pkg::REG_ONE_THRESHOLD:
                begin
                    cfg_reg.one_threshold_ticks <= pwdata[swhsr_pkg::CFG_W-1:0];
                end
                swhsr_pkg::REG_MAX_BIT:
                begin
                    cfg_reg.max_bit_ticks <= pwdata[swhsr_pkg::CFG_W-1:0];
                end
                default:
                begin
                    cfg_reg.timeout_ticks <= pwdata[swhsr_pkg::CFG_W-1:0];
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            swhsr_pkg::REG_START_LOW:
            begin
                prdata = swhsr_pkg::APB_DATA_W'(cfg_reg.start_low_ticks);
            end
            swhsr_pkg::REG_ONE_THRESHOLD:
            begin
                prdata = swhsr_pkg::APB_DATA_W'(cfg_reg.one_threshold_ticks);
            end
            swhsr_pkg::REG_MAX_BIT:
            begin
                prdata = swhsr_pkg::APB_DATA_W'(cfg_reg.max_bit_ticks);
            end
            default:
            begin
                prdata = swhsr_pkg::APB_DATA_W'(cfg_reg.timeout_ticks);
            end
        endcase
    end

    swhsr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    swhsr_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== design/swhsr_checker.sv =====
// Port-level checks for the single-wire humidity sensor reader, and the bind
// that attaches them to the top level. Depends on swhsr_pkg.
module swhsr_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [swhsr_pkg::M_TDATA_W-1:0]  m_tdata
);

    swhsr_pkg::result_t res;

    assign res = m_tdata;

    // A word that is held back must not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The frame check ends the measurement in the same word.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.done_res |-> !res.busy_res && !res.drive_low)
        else $error("done reported while still busy");

    // The line is only pulled low during a measurement.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.drive_low |-> res.busy_res)
        else $error("line driven low outside a measurement");

    // A frame never holds more than forty bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res.bits_received <= swhsr_pkg::BITCNT_W'(swhsr_pkg::FRAME_BITS))
        else $error("bit count exceeds the frame length");

endmodule

bind single_wire_humidity_sensor_reader swhsr_checker u_swhsr_checker (.*);
